// ===== rtl/rarst_pkg.sv =====
// ----------------------------------------------------------------------------
// rarst_pkg: shared types and constants of the range add / range sum tree
// Holds the field widths, the opcode and command kind codes, and the command
// record that travels from the front end to the tree sequencer.
// ----------------------------------------------------------------------------
package rarst_pkg;

	localparam int IDX_W = 10;   // element index width of the range fields
	localparam int LEN_W = 11;   // active length width, also node bound width
	localparam int VAL_W = 32;   // add amount width
	localparam int SUM_W = 64;   // element and node sum width

	localparam logic [LEN_W-1:0] LEN_RESET = 11'd1024;

	localparam logic OP_ADD   = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic [1:0] CMD_ADD   = 2'd0;
	localparam logic [1:0] CMD_QUERY = 2'd1;
	localparam logic [1:0] CMD_ZERO  = 2'd2;  // query over an empty range

	typedef struct packed {
		logic [1:0]       kind;
		logic [IDX_W-1:0] s;
		logic [IDX_W-1:0] e;
		logic [VAL_W-1:0] v;
		logic [LEN_W-1:0] len;
	} cmd_t;

endpackage

// ===== rtl/rarst_ram.sv =====
// ----------------------------------------------------------------------------
// rarst_ram: generic single write port, single read port RAM
// One write and one registered read per cycle, at independent addresses.
// ----------------------------------------------------------------------------
module rarst_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/rarst_front.sv =====
// ----------------------------------------------------------------------------
// rarst_front: request intake, range clipping and command queue
// Holds the length register, clips each range, drops empty adds and queues
// the rest as commands for the tree sequencer.
// ----------------------------------------------------------------------------
module rarst_front #(
	parameter int MAX_ELEMENTS = 1024
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [rarst_pkg::LEN_W-1:0]    cfg_data,
	input  logic                           push,
	output logic                           full,
	input  logic                           op,
	input  logic [rarst_pkg::IDX_W-1:0]    range_start,
	input  logic [rarst_pkg::IDX_W-1:0]    range_end,
	input  logic [rarst_pkg::VAL_W-1:0]    add_value,
	input  logic                           hold,
	output logic                           cmd_valid,
	output rarst_pkg::cmd_t                cmd,
	input  logic                           cmd_take
);

	localparam int LW = rarst_pkg::LEN_W;
	localparam int IW = rarst_pkg::IDX_W;

	logic [LW-1:0]   active_q;
	logic [LW-1:0]   len;
	logic [LW-1:0]   last;
	logic [IW-1:0]   e_clip;
	logic            empty_range;
	logic            accept;
	logic            enq;
	rarst_pkg::cmd_t new_cmd;
	rarst_pkg::cmd_t q_q [2];
	logic            wp_q;
	logic            rp_q;
	logic [1:0]      cnt_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= rarst_pkg::LEN_RESET;
		end else if (cfg_valid) begin
			active_q <= cfg_data;
		end
	end

	always_comb begin
		if (active_q == '0) begin
			len = LW'(1);
		end else if (32'(active_q) > MAX_ELEMENTS) begin
			len = LW'(MAX_ELEMENTS);
		end else begin
			len = active_q;
		end
	end

	assign last        = len - LW'(1);
	assign e_clip      = ({1'b0, range_end} > last) ? last[IW-1:0] : range_end;
	assign empty_range = ({1'b0, range_start} >= len) || (range_start > e_clip);

	always_comb begin
		new_cmd.s   = range_start;
		new_cmd.e   = e_clip;
		new_cmd.v   = add_value;
		new_cmd.len = len;
		if (op == rarst_pkg::OP_ADD) begin
			new_cmd.kind = rarst_pkg::CMD_ADD;
		end else if (empty_range) begin
			new_cmd.kind = rarst_pkg::CMD_ZERO;
		end else begin
			new_cmd.kind = rarst_pkg::CMD_QUERY;
		end
	end

	assign full      = hold || (cnt_q == 2'd2);
	assign accept    = push && !full;
	// An add over an empty range leaves the array as it is: it is taken and dropped.
	assign enq       = accept && !((op == rarst_pkg::OP_ADD) && empty_range);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = q_q[rp_q];

	always_ff @(posedge clk) begin
		if (enq) begin
			q_q[wp_q] <= new_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (enq) begin
				wp_q <= !wp_q;
			end
			if (cmd_take) begin
				rp_q <= !rp_q;
			end
			cnt_q <= cnt_q + 2'(enq) - 2'(cmd_take);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("command queue count out of range");

endmodule

// ===== rtl/rarst_back.sv =====
// ----------------------------------------------------------------------------
// rarst_back: lazy segment tree sequencer
// Walks the tree with an explicit stack, one access per RAM port per step, keeps
// node sums and pending additions in two RAMs and holds one result.
// ----------------------------------------------------------------------------
module rarst_back #(
	parameter int MAX_ELEMENTS = 1024
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cmd_valid,
	input  rarst_pkg::cmd_t             cmd,
	output logic                        cmd_take,
	output logic                        clearing,
	input  logic                        pop,
	output logic                        empty,
	output logic [rarst_pkg::SUM_W-1:0] range_sum
);

	localparam int STORE_DEPTH = 2 * MAX_ELEMENTS;
	localparam int AW  = $clog2(STORE_DEPTH);
	localparam int NW  = AW + 1;
	localparam int SD  = $clog2(MAX_ELEMENTS) + 2;
	localparam int SPW = $clog2(SD + 1);
	localparam int STW = $clog2(SD);
	localparam int LW  = rarst_pkg::LEN_W;
	localparam int IW  = rarst_pkg::IDX_W;
	localparam int SW  = rarst_pkg::SUM_W;
	localparam int VW  = rarst_pkg::VAL_W;
	localparam int PW  = VW + LW;

	localparam logic [3:0] ST_CLEAR = 4'd0;
	localparam logic [3:0] ST_IDLE  = 4'd1;
	localparam logic [3:0] ST_VISIT = 4'd2;
	localparam logic [3:0] ST_READ  = 4'd3;
	localparam logic [3:0] ST_MUL0  = 4'd4;
	localparam logic [3:0] ST_MUL1  = 4'd5;
	localparam logic [3:0] ST_WRITE = 4'd6;
	localparam logic [3:0] ST_CHL   = 4'd7;
	localparam logic [3:0] ST_CHR   = 4'd8;
	localparam logic [3:0] ST_POST  = 4'd9;
	localparam logic [3:0] ST_RET   = 4'd10;
	localparam logic [3:0] ST_J0    = 4'd11;
	localparam logic [3:0] ST_J1    = 4'd12;
	localparam logic [3:0] ST_J2    = 4'd13;
	localparam logic [3:0] ST_EMIT  = 4'd14;

	logic [3:0]    state_q;
	logic [AW-1:0] clr_q;
	logic          add_q;
	logic [IW-1:0] s_q;
	logic [IW-1:0] e_q;
	logic [VW-1:0] v_q;
	logic [NW-1:0] node_q;
	logic [LW-1:0] lo_q;
	logic [LW-1:0] hi_q;
	logic [SW-1:0] d_q;
	logic [SW-1:0] sum_q;
	logic [PW-1:0] prod0_q;
	logic [SW-1:0] inc_q;
	logic [SW-1:0] l_q;
	logic [SW-1:0] acc_q;
	logic          res_valid_q;
	logic [SW-1:0] res_q;
	logic [SPW-1:0] sp_q;
	logic [NW-1:0] stk_node_q  [SD];
	logic [LW-1:0] stk_lo_q    [SD];
	logic [LW-1:0] stk_hi_q    [SD];
	logic          stk_right_q [SD];

	logic          node_ok;
	logic          overlap;
	logic          covered;
	logic          leaf;
	logic [LW-1:0] span;
	logic [LW-1:0] mid;
	logic [NW-1:0] left;
	logic [NW-1:0] right;
	logic          left_ok;
	logic          right_ok;
	logic [STW-1:0] top_idx;
	logic [LW-1:0] top_mid;
	logic [SW-1:0] v_ext;
	logic [SW-1:0] d_new;
	logic [31:0]   mul_hi;
	logic [SW-1:0] sum_next;

	logic          sum_we;
	logic [AW-1:0] sum_waddr;
	logic [SW-1:0] sum_wdata;
	logic [AW-1:0] sum_raddr;
	logic [SW-1:0] sum_rd;
	logic          pend_we;
	logic [AW-1:0] pend_waddr;
	logic [SW-1:0] pend_wdata;
	logic [AW-1:0] pend_raddr;
	logic [SW-1:0] pend_rd;

	assign node_ok  = node_q < NW'(STORE_DEPTH);
	assign overlap  = !(({1'b0, s_q} > hi_q) || ({1'b0, e_q} < lo_q) || (lo_q > hi_q));
	assign covered  = (lo_q >= {1'b0, s_q}) && (hi_q <= {1'b0, e_q});
	assign leaf     = (lo_q == hi_q);
	assign span     = hi_q - lo_q + LW'(1);
	assign mid      = LW'(({1'b0, lo_q} + {1'b0, hi_q}) >> 1);
	assign left     = {node_q[NW-2:0], 1'b0};
	assign right    = {node_q[NW-2:0], 1'b1};
	assign left_ok  = left < NW'(STORE_DEPTH);
	assign right_ok = right < NW'(STORE_DEPTH);
	assign top_idx  = STW'(sp_q - SPW'(1));
	assign top_mid  = LW'(({1'b0, stk_lo_q[top_idx]} + {1'b0, stk_hi_q[top_idx]}) >> 1);
	assign v_ext    = {{(SW-VW){v_q[VW-1]}}, v_q};
	// The pending amount of the node and, at a fully covered node of an add, the new
	// amount are applied together: same sum change, same hand-over to the children.
	assign d_new    = pend_rd + ((add_q && covered) ? v_ext : '0);
	assign mul_hi   = d_q[SW-1:32] * 32'(span);
	assign sum_next = sum_q + inc_q;

	assign cmd_take  = (state_q == ST_IDLE) && cmd_valid;
	assign clearing  = (state_q == ST_CLEAR);
	assign empty     = !res_valid_q;
	assign range_sum = res_q;

	always_comb begin
		sum_raddr  = node_q[AW-1:0];
		pend_raddr = node_q[AW-1:0];
		sum_we     = 1'b0;
		sum_waddr  = node_q[AW-1:0];
		sum_wdata  = sum_next;
		pend_we    = 1'b0;
		pend_waddr = node_q[AW-1:0];
		pend_wdata = '0;
		case (state_q)
			ST_CLEAR: begin
				sum_we     = 1'b1;
				sum_waddr  = clr_q;
				sum_wdata  = '0;
				pend_we    = 1'b1;
				pend_waddr = clr_q;
			end
			ST_WRITE: begin
				sum_we     = 1'b1;
				pend_we    = 1'b1;
				pend_raddr = left[AW-1:0];
			end
			ST_CHL: begin
				pend_we    = left_ok;
				pend_waddr = left[AW-1:0];
				pend_wdata = pend_rd + d_q;
				pend_raddr = right[AW-1:0];
			end
			ST_CHR: begin
				pend_we    = right_ok;
				pend_waddr = right[AW-1:0];
				pend_wdata = pend_rd + d_q;
			end
			ST_J0: begin
				sum_raddr = left[AW-1:0];
			end
			ST_J1: begin
				sum_raddr = right[AW-1:0];
			end
			ST_J2: begin
				sum_we    = 1'b1;
				sum_wdata = l_q + (right_ok ? sum_rd : '0);
			end
			default: begin
			end
		endcase
	end

	rarst_ram #(.WIDTH(SW), .DEPTH(STORE_DEPTH)) u_sum_ram (
		.clk   (clk),
		.we    (sum_we),
		.waddr (sum_waddr),
		.wdata (sum_wdata),
		.raddr (sum_raddr),
		.rdata (sum_rd)
	);

	rarst_ram #(.WIDTH(SW), .DEPTH(STORE_DEPTH)) u_pend_ram (
		.clk   (clk),
		.we    (pend_we),
		.waddr (pend_waddr),
		.wdata (pend_wdata),
		.raddr (pend_raddr),
		.rdata (pend_rd)
	);

	// Payload and stack registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				s_q    <= cmd.s;
				e_q    <= cmd.e;
				v_q    <= cmd.v;
				lo_q   <= '0;
				hi_q   <= cmd.len - LW'(1);
				node_q <= NW'(1);
				acc_q  <= '0;
			end
			ST_READ: begin
				d_q   <= d_new;
				sum_q <= sum_rd;
			end
			ST_MUL0: begin
				prod0_q <= PW'(d_q[VW-1:0]) * PW'(span);
			end
			ST_MUL1: begin
				inc_q <= {32'(prod0_q[PW-1:32]) + mul_hi, prod0_q[31:0]};
			end
			ST_WRITE: begin
				sum_q <= sum_next;
			end
			ST_POST: begin
				if (overlap && covered) begin
					if (!add_q) begin
						acc_q <= acc_q + sum_q;
					end
				end else if (overlap) begin
					stk_node_q[sp_q[STW-1:0]]  <= node_q;
					stk_lo_q[sp_q[STW-1:0]]    <= lo_q;
					stk_hi_q[sp_q[STW-1:0]]    <= hi_q;
					stk_right_q[sp_q[STW-1:0]] <= 1'b0;
					node_q <= left;
					hi_q   <= mid;
				end
			end
			ST_RET: begin
				if (sp_q != '0) begin
					if (!stk_right_q[top_idx]) begin
						stk_right_q[top_idx] <= 1'b1;
						node_q <= {stk_node_q[top_idx][NW-2:0], 1'b1};
						lo_q   <= top_mid + LW'(1);
						hi_q   <= stk_hi_q[top_idx];
					end else begin
						node_q <= stk_node_q[top_idx];
						lo_q   <= stk_lo_q[top_idx];
						hi_q   <= stk_hi_q[top_idx];
					end
				end
			end
			ST_J1: begin
				l_q <= left_ok ? sum_rd : '0;
			end
			ST_EMIT: begin
				if (!res_valid_q) begin
					res_q <= acc_q;
				end
			end
			default: begin
			end
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			add_q       <= 1'b0;
			sp_q        <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (pop && res_valid_q) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(STORE_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (cmd_valid) begin
						add_q <= (cmd.kind == rarst_pkg::CMD_ADD);
						sp_q  <= '0;
						if (cmd.kind == rarst_pkg::CMD_ZERO) begin
							state_q <= ST_EMIT;
						end else begin
							state_q <= ST_VISIT;
						end
					end
				end
				ST_VISIT: begin
					if (!node_ok || (!add_q && !overlap)) begin
						state_q <= ST_RET;
					end else begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					if ((pend_rd == '0) && (d_new == '0)) begin
						state_q <= ST_POST;
					end else begin
						state_q <= ST_MUL0;
					end
				end
				ST_MUL0: begin
					state_q <= ST_MUL1;
				end
				ST_MUL1: begin
					state_q <= ST_WRITE;
				end
				ST_WRITE: begin
					state_q <= leaf ? ST_POST : ST_CHL;
				end
				ST_CHL: begin
					state_q <= ST_CHR;
				end
				ST_CHR: begin
					state_q <= ST_POST;
				end
				ST_POST: begin
					if (overlap && !covered) begin
						sp_q    <= sp_q + SPW'(1);
						state_q <= ST_VISIT;
					end else begin
						state_q <= ST_RET;
					end
				end
				ST_RET: begin
					if (sp_q == '0) begin
						state_q <= add_q ? ST_IDLE : ST_EMIT;
					end else if (!stk_right_q[top_idx]) begin
						state_q <= ST_VISIT;
					end else begin
						sp_q    <= sp_q - SPW'(1);
						state_q <= add_q ? ST_J0 : ST_RET;
					end
				end
				ST_J0: begin
					state_q <= ST_J1;
				end
				ST_J1: begin
					state_q <= ST_J2;
				end
				ST_J2: begin
					state_q <= ST_RET;
				end
				ST_EMIT: begin
					if (!res_valid_q) begin
						res_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= SPW'(SD))
		else $error("tree walk stack overflow");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_VISIT) |-> (node_q != '0))
		else $error("visit of node zero");

	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !pop) |=> (res_valid_q && $stable(res_q)))
		else $error("waiting result lost or changed");

endmodule

// ===== rtl/range_add_range_sum_tree.sv =====
// ----------------------------------------------------------------------------
// range_add_range_sum_tree: range add / range sum store on a lazy segment tree
// Keeps an array of signed 64-bit elements, adds a value over a range and
// returns wrapped range sums.
// ----------------------------------------------------------------------------
// Usage. Requests enter on a queue style port: a request is taken at a clock
// edge with push high and full low. An add request (op 0) changes the array and
// gives no result; a query request (op 1) gives one result, the sum of the range.
// Results leave in request order: while empty is low, range_sum holds the oldest
// result, and it is taken at an edge with pop high. The length register is
// written through cfg_valid/cfg_data (cfg_ready is always high); the user is
// to write it only while idle, which the block does not enforce. Ranges are
// clipped to the active length; an empty query returns zero. A request walks
// the tree with a stack based sequencer, one access per RAM port per step. A
// node passes visit, read and post steps; a pending amount there adds multiply
// steps, a sum write and, above a leaf, pushes to both children; a return step
// follows. An add rebuilds each split node's sum in join steps. A query over
// the whole array reads only the root; a worst case add over 1024 elements
// touches about 4 nodes per level. The walk is limited by the single read port
// of the sum and pending RAMs. A two entry command queue lets requests be taken
// while the walk runs. After reset both RAMs are cleared, one entry a cycle
// over all 2*MAX_ELEMENTS entries, with full held high; the length register
// resets to 1024. When the receiver stalls, adds keep running; a second query
// waits for the result slot, and full rises once the command queue fills.
// ----------------------------------------------------------------------------
module range_add_range_sum_tree #(
	parameter int MAX_ELEMENTS = 1024
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [rarst_pkg::LEN_W-1:0] cfg_data,
	input  logic                        push,
	output logic                        full,
	input  logic                        op,
	input  logic [rarst_pkg::IDX_W-1:0] range_start,
	input  logic [rarst_pkg::IDX_W-1:0] range_end,
	input  logic [rarst_pkg::VAL_W-1:0] add_value,
	output logic                        empty,
	input  logic                        pop,
	output logic [rarst_pkg::SUM_W-1:0] range_sum
);

	// Commands pass from the intake side to the tree sequencer here.
	logic            cmd_valid;
	logic            cmd_take;
	rarst_pkg::cmd_t cmd;
	// High while the sequencer clears its RAMs after reset.
	logic            clearing;

	rarst_front #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.push        (push),
		.full        (full),
		.op          (op),
		.range_start (range_start),
		.range_end   (range_end),
		.add_value   (add_value),
		.hold        (clearing),
		.cmd_valid   (cmd_valid),
		.cmd         (cmd),
		.cmd_take    (cmd_take)
	);

	rarst_back #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_take  (cmd_take),
		.clearing  (clearing),
		.pop       (pop),
		.empty     (empty),
		.range_sum (range_sum)
	);

endmodule
